### rtl/svem_pkg.sv
// Shared types, event codes and sizes for the supply voltage event monitor.
package svem_pkg;

  // Field widths
  localparam int VOLT_W  = 14;
  localparam int RATE_W  = 10;
  localparam int TREND_W = 4;
  localparam int CODE_W  = 3;
  localparam int PSTATE_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 14;

  // Event codes as seen on the result channel
  localparam logic [CODE_W-1:0] EV_FALLING   = 3'd0;
  localparam logic [CODE_W-1:0] EV_LOW       = 3'd1;
  localparam logic [CODE_W-1:0] EV_OVER      = 3'd2;
  localparam logic [CODE_W-1:0] EV_NORMAL    = 3'd3;
  localparam logic [CODE_W-1:0] EV_SOLAR_ON  = 3'd4;
  localparam logic [CODE_W-1:0] EV_SOLAR_OFF = 3'd5;
  localparam logic [CODE_W-1:0] EV_USB_ON    = 3'd6;
  localparam logic [CODE_W-1:0] EV_USB_OFF   = 3'd7;

  // Power state, coded like the first four event codes
  localparam logic [PSTATE_W-1:0] PS_FALLING = 2'd0;
  localparam logic [PSTATE_W-1:0] PS_LOW     = 2'd1;
  localparam logic [PSTATE_W-1:0] PS_OVER    = 2'd2;
  localparam logic [PSTATE_W-1:0] PS_NORMAL  = 2'd3;

  // Fall run saturation
  localparam logic [TREND_W-1:0] RUN_MAX = 4'd15;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FALL_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TREND     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_TH    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OVER_TH   = 2'd3;

  // Configuration reset values
  localparam logic [RATE_W-1:0]  FALL_RATE_RST = 10'd20;
  localparam logic [TREND_W-1:0] TREND_RST     = 4'd3;
  localparam logic [VOLT_W-1:0]  LOW_TH_RST    = 14'd4700;
  localparam logic [VOLT_W-1:0]  OVER_TH_RST   = 14'd5300;

  // Queue between the classifier and the event serializer
  localparam int QUEUE_AW    = 1;
  localparam int QUEUE_DEPTH = 2 ** QUEUE_AW;

  // Event slots of one sample, in emission order
  localparam int SLOT_N = 4;

  typedef struct packed {
    logic [VOLT_W-1:0] voltage_mv;
    logic              solar_chg;
    logic              usb_pwr;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] event_code;
    logic              last_event;
  } out_item_t;

  // Classified events of one sample
  typedef struct packed {
    logic                fall_v;
    logic                pwr_v;
    logic [PSTATE_W-1:0] pwr_code;
    logic                sol_v;
    logic                sol_on;
    logic                usb_v;
    logic                usb_on;
  } evt_bundle_t;

  // Push side of the queue
  typedef struct packed {
    logic        push;
    evt_bundle_t data;
  } q_wr_t;

  // Pop side of the queue
  typedef struct packed {
    logic        valid;
    evt_bundle_t data;
  } q_rd_t;

endpackage

### rtl/svem_front.sv
// Front end: configuration registers, sample state and event classification.
module svem_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  svem_pkg::in_item_t              in_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [svem_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [svem_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            q_full,
  output svem_pkg::q_wr_t                 q_wr
);
  import svem_pkg::*;

  logic [RATE_W-1:0]   fall_rate_r;
  logic [TREND_W-1:0]  trend_r;
  logic [VOLT_W-1:0]   low_th_r;
  logic [VOLT_W-1:0]   over_th_r;

  logic [VOLT_W-1:0]   prev_volt_r;
  logic [TREND_W-1:0]  run_r, run_nxt;
  logic [PSTATE_W-1:0] pstate_r, pstate_nxt;
  logic                solar_r;
  logic                usb_r;

  logic                accept;
  logic                fall;
  logic [VOLT_W-1:0]   drop;
  logic [PSTATE_W-1:0] pstate_mid;
  evt_bundle_t         bundle;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fall_rate_r <= FALL_RATE_RST;
      trend_r     <= TREND_RST;
      low_th_r    <= LOW_TH_RST;
      over_th_r   <= OVER_TH_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FALL_RATE: fall_rate_r <= cfg_data[RATE_W-1:0];
        CFG_TREND:     trend_r     <= cfg_data[TREND_W-1:0];
        CFG_LOW_TH:    low_th_r    <= cfg_data[VOLT_W-1:0];
        CFG_OVER_TH:   over_th_r   <= cfg_data[VOLT_W-1:0];
        default: ;
      endcase
    end
  end

  // Fall detection and run counting.
  assign drop = prev_volt_r - in_data.voltage_mv;
  assign fall = (prev_volt_r > in_data.voltage_mv) &&
                (drop > {{(VOLT_W-RATE_W){1'b0}}, fall_rate_r});

  always_comb begin
    if (!fall) begin
      run_nxt = '0;
    end else if (run_r < RUN_MAX) begin
      run_nxt = run_r + 1'b1;
    end else begin
      run_nxt = run_r;
    end
  end

  // Classify the sample into its events.
  always_comb begin
    bundle     = '0;
    pstate_mid = pstate_r;
    if (run_nxt >= trend_r) begin
      bundle.fall_v = 1'b1;
      pstate_mid    = PS_FALLING;
    end
    pstate_nxt = pstate_mid;
    priority if (in_data.voltage_mv < low_th_r && pstate_mid != PS_LOW) begin
      pstate_nxt = PS_LOW;
    end else if (in_data.voltage_mv > over_th_r && pstate_mid != PS_OVER) begin
      pstate_nxt = PS_OVER;
    end else if (in_data.voltage_mv >= low_th_r && in_data.voltage_mv <= over_th_r &&
                 pstate_mid != PS_NORMAL) begin
      pstate_nxt = PS_NORMAL;
    end else begin
      pstate_nxt = pstate_mid;
    end
    bundle.pwr_v    = (pstate_nxt != pstate_mid);
    bundle.pwr_code = pstate_nxt;
    bundle.sol_v    = (in_data.solar_chg != solar_r);
    bundle.sol_on   = in_data.solar_chg;
    bundle.usb_v    = (in_data.usb_pwr != usb_r);
    bundle.usb_on   = in_data.usb_pwr;
  end

  // Sample state update on each accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_volt_r <= '0;
      run_r       <= '0;
      pstate_r    <= PS_LOW;
      solar_r     <= 1'b0;
      usb_r       <= 1'b0;
    end else if (accept) begin
      prev_volt_r <= in_data.voltage_mv;
      run_r       <= run_nxt;
      pstate_r    <= pstate_nxt;
      solar_r     <= in_data.solar_chg;
      usb_r       <= in_data.usb_pwr;
    end
  end

  // Samples without events are not queued.
  assign q_wr.push = accept && (bundle.fall_v || bundle.pwr_v || bundle.sol_v || bundle.usb_v);
  assign q_wr.data = bundle;

endmodule

### rtl/svem_queue.sv
// Short queue of classified event bundles between front and back end.
module svem_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  svem_pkg::q_wr_t q_wr,
  output logic            q_full,
  input  logic            q_pop,
  output svem_pkg::q_rd_t q_rd
);
  import svem_pkg::*;

  evt_bundle_t           mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_r;
  logic [QUEUE_AW-1:0]   rd_ptr_r;
  logic [QUEUE_AW:0]     count_r;
  logic                  do_pop;

  assign q_full     = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign q_rd.valid = (count_r != '0);
  assign q_rd.data  = mem_r[rd_ptr_r];
  assign do_pop     = q_pop && q_rd.valid;

  // Storage, written only when the front end pushes.
  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      mem_r[wr_ptr_r] <= q_wr.data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (q_wr.push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({q_wr.push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

### rtl/svem_back.sv
// Back end: serializes queued event bundles into one result per cycle while the receiver accepts.
module svem_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  svem_pkg::q_rd_t      q_rd,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output svem_pkg::out_item_t  out_data
);
  import svem_pkg::*;

  logic [SLOT_N-1:0]   mask_r, mask_nxt;
  logic [PSTATE_W-1:0] pwr_code_r;
  logic                sol_on_r;
  logic                usb_on_r;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r;

  logic [SLOT_N-1:0]   sel_oh;
  logic [SLOT_N-1:0]   mask_after;
  logic [CODE_W-1:0]   sel_code;
  logic                cur_any;
  logic                out_load;
  logic                cur_done;

  assign cur_any  = (mask_r != '0);
  assign out_load = cur_any && (!out_valid_r || out_ready);

  // Pick the earliest pending slot and its event code.
  assign sel_oh     = mask_r & (~mask_r + 1'b1);
  assign mask_after = mask_r & ~sel_oh;

  always_comb begin
    priority if (mask_r[0]) begin
      sel_code = EV_FALLING;
    end else if (mask_r[1]) begin
      sel_code = {1'b0, pwr_code_r};
    end else if (mask_r[2]) begin
      sel_code = sol_on_r ? EV_SOLAR_ON : EV_SOLAR_OFF;
    end else begin
      sel_code = usb_on_r ? EV_USB_ON : EV_USB_OFF;
    end
  end

  // Take the next bundle as the current one runs out.
  assign cur_done = !cur_any || (out_load && (mask_after == '0));
  assign q_pop    = q_rd.valid && cur_done;

  always_comb begin
    mask_nxt = mask_r;
    if (q_pop) begin
      mask_nxt = {q_rd.data.usb_v, q_rd.data.sol_v, q_rd.data.pwr_v, q_rd.data.fall_v};
    end else if (out_load) begin
      mask_nxt = mask_after;
    end
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers of the current bundle and the output stage.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      pwr_code_r <= q_rd.data.pwr_code;
      sol_on_r   <= q_rd.data.sol_on;
      usb_on_r   <= q_rd.data.usb_on;
    end
    if (out_load) begin
      out_data_r.event_code <= sel_code;
      out_data_r.last_event <= (mask_after == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/supply_voltage_event_monitor.sv
// Top level of the supply voltage event monitor.
//
// One input transaction carries a rail voltage sample in millivolts and the
// solar and USB flags. Each sample yields zero to four result transactions,
// in the order power falling, power state change, solar edge, USB edge; the
// final one of a sample has last_event set. A sample with no events yields
// no result.
// The front end takes a sample in the cycle it is offered while the two-entry
// event queue has room, so samples may arrive back to back. The back end
// emits one event per cycle while the receiver accepts, through a registered
// output: a sample's bundle is written into the queue, moved into the back
// end's slot mask, then loaded event by event into the output register.
// When the receiver stalls, the output register holds its transaction, the
// queue fills, and in_ready drops once both queue entries are taken.
// Configuration writes are taken every cycle (cfg_ready stays high) and are
// to be issued only while no events are pending.
// Synchronous reset restores the register defaults, clears the sample
// history, sets the power state to low battery and empties the queue.
module supply_voltage_event_monitor (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  svem_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output svem_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [svem_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [svem_pkg::CFG_DATA_W-1:0] cfg_data
);
  import svem_pkg::*;

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;

  // Classifier with configuration and sample history.
  svem_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_wr      (q_wr)
  );

  // Event bundle queue.
  svem_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_pop  (q_pop),
    .q_rd   (q_rd)
  );

  // Event serializer and output register.
  svem_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_rd      (q_rd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### dv/tb.sv
// Self-checking testbench for the supply voltage event monitor, with an event scoreboard.
`timescale 1ns / 100ps

module tb;
  import svem_pkg::*;

  // Tracks the monitor's history and registers and holds the events each sample should raise.
  class event_scoreboard;
    logic [RATE_W-1:0]   fall_rate;
    logic [TREND_W-1:0]  trend_need;
    logic [VOLT_W-1:0]   low_th;
    logic [VOLT_W-1:0]   over_th;
    logic [VOLT_W-1:0]   last_volt;
    logic [TREND_W-1:0]  fall_run;
    logic [PSTATE_W-1:0] pstate;
    logic                solar_was;
    logic                usb_was;
    logic [CODE_W-1:0]   sample_codes[$];
    out_item_t           pending_events[$];
    int                  errors;

    function new();
      fall_rate  = FALL_RATE_RST;
      trend_need = TREND_RST;
      low_th     = LOW_TH_RST;
      over_th    = OVER_TH_RST;
      last_volt  = '0;
      fall_run   = '0;
      pstate     = PS_LOW;
      solar_was  = 1'b0;
      usb_was    = 1'b0;
      errors     = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_FALL_RATE: fall_rate  = data[RATE_W-1:0];
        CFG_TREND:     trend_need = data[TREND_W-1:0];
        CFG_LOW_TH:    low_th     = data[VOLT_W-1:0];
        CFG_OVER_TH:   over_th    = data[VOLT_W-1:0];
        default: ;
      endcase
    endfunction

    function int outstanding();
      return pending_events.size();
    endfunction

    function void report(string what, int got, int want);
      $display("[%0t] %s mismatch: got %0d, expected %0d", $time, what, got, want);
      errors++;
    endfunction

    // Works out the events of one accepted sample, in emission order.
    function void note_sample(in_item_t s);
      int        drop;
      out_item_t ev;
      drop = int'(last_volt) - int'(s.voltage_mv);
      last_volt = s.voltage_mv;
      sample_codes.delete();

      // A steep fall extends the run, anything else breaks it.
      if (drop > int'(fall_rate)) begin
        if (fall_run < RUN_MAX) fall_run++;
      end else begin
        fall_run = '0;
      end
      if (fall_run >= trend_need) begin
        pstate = PS_FALLING;
        sample_codes.push_back(EV_FALLING);
      end

      // Power state change, low first, then overcharge, then normal.
      if (s.voltage_mv < low_th && pstate != PS_LOW) begin
        pstate = PS_LOW;
        sample_codes.push_back(EV_LOW);
      end else if (s.voltage_mv > over_th && pstate != PS_OVER) begin
        pstate = PS_OVER;
        sample_codes.push_back(EV_OVER);
      end else if (s.voltage_mv >= low_th && s.voltage_mv <= over_th &&
                   pstate != PS_NORMAL) begin
        pstate = PS_NORMAL;
        sample_codes.push_back(EV_NORMAL);
      end

      // Flag edges.
      if (s.solar_chg != solar_was) begin
        sample_codes.push_back(s.solar_chg ? EV_SOLAR_ON : EV_SOLAR_OFF);
        solar_was = s.solar_chg;
      end
      if (s.usb_pwr != usb_was) begin
        sample_codes.push_back(s.usb_pwr ? EV_USB_ON : EV_USB_OFF);
        usb_was = s.usb_pwr;
      end

      foreach (sample_codes[i]) begin
        ev.event_code = sample_codes[i];
        ev.last_event = (i == sample_codes.size() - 1);
        pending_events.push_back(ev);
      end
    endfunction

    // Compares one accepted result with the oldest pending event.
    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_events.size() == 0) begin
        report("unexpected result, event_code", int'(got.event_code), -1);
        return;
      end
      want = pending_events.pop_front();
      if (got.event_code !== want.event_code)
        report("event_code", int'(got.event_code), int'(want.event_code));
      if (got.last_event !== want.last_event)
        report("last_event", int'(got.last_event), int'(want.last_event));
    endfunction
  endclass

  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_MV = 16383;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bit idle_on;
  event_scoreboard sb = new();

  supply_voltage_event_monitor uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock.
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Offers one sample and waits for its transaction.
  task automatic send_sample(input int volt, input logic solar, input logic usb);
    in_item_t s;
    int       gap;
    gap = idle_on ? $urandom_range(0, 14) : 0;
    s.voltage_mv = volt[VOLT_W-1:0];
    s.solar_chg  = solar;
    s.usb_pwr    = usb;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_sample(s);
    @(negedge clk);
  endtask

  // Stops sending and waits until every pending event has come out.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes all four registers in back-to-back transactions.
  task automatic configure(input int rate, input int trend, input int low, input int over);
    logic [CFG_IDX_W-1:0]  idx[4];
    logic [CFG_DATA_W-1:0] val[4];
    idx[0] = CFG_FALL_RATE; val[0] = rate[CFG_DATA_W-1:0];
    idx[1] = CFG_TREND;     val[1] = trend[CFG_DATA_W-1:0];
    idx[2] = CFG_LOW_TH;    val[2] = low[CFG_DATA_W-1:0];
    idx[3] = CFG_OVER_TH;   val[3] = over[CFG_DATA_W-1:0];
    cfg_valid <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (cfg_ready !== 1'b1);
      sb.write_register(idx[i], val[i]);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic int clamp_mv(int x);
    return (x < 0) ? 0 : ((x > MAX_MV) ? MAX_MV : x);
  endfunction

  // Random samples: mostly falling ramps, the rest noise around the thresholds, random levels or rail extremes.
  task automatic random_phase(input int count, input bit pause_midway);
    int   ramp_left;
    int   ramp_v;
    int   step;
    int   volt;
    logic solar;
    logic usb;
    ramp_left = 0;
    ramp_v    = 0;
    solar     = sb.solar_was;
    usb       = sb.usb_was;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 15) == 0) idle_on = ~idle_on;
      if (pause_midway && i == count / 2) drain();
      if (ramp_left == 0 && $urandom_range(0, 2) != 0) begin
        ramp_left = $urandom_range(3, 20);
        ramp_v    = $urandom_range(6000, MAX_MV);
      end
      if (ramp_left > 0) begin
        if ($urandom_range(0, 5) == 0)
          step = $urandom_range(0, int'(sb.fall_rate));
        else
          step = int'(sb.fall_rate) + $urandom_range(1, 60);
        ramp_v = clamp_mv(ramp_v - step);
        volt = ramp_v;
        ramp_left--;
      end else begin
        case ($urandom_range(0, 3))
          0: volt = $urandom_range(0, MAX_MV);
          1: volt = clamp_mv(int'(sb.low_th) + $urandom_range(0, 4) - 2);
          2: volt = clamp_mv(int'(sb.over_th) + $urandom_range(0, 4) - 2);
          default: volt = $urandom_range(0, 1) ? MAX_MV : 0;
        endcase
      end
      if ($urandom_range(0, 3) == 0) solar = ~solar;
      if ($urandom_range(0, 3) == 0) usb = ~usb;
      send_sample(volt, solar, usb);
    end
  endtask

  // Result side: random stalls, then checks each accepted transaction.
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 14) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_result(out_data);
      @(negedge clk);
    end
  end

  // Main sequence.
  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_FALL_RATE;
    cfg_data  = '0;
    idle_on   = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: state changes, flag edges, a long fall, exact thresholds.
    send_sample(5000, 1'b0, 1'b0);
    send_sample(5000, 1'b1, 1'b1);
    send_sample(MAX_MV, 1'b1, 1'b1);
    send_sample(MAX_MV, 1'b0, 1'b0);
    send_sample(16000, 1'b0, 1'b0);
    send_sample(15000, 1'b0, 1'b0);
    send_sample(14000, 1'b0, 1'b0);
    send_sample(13000, 1'b1, 1'b1);
    send_sample(0, 1'b0, 1'b0);
    send_sample(0, 1'b0, 1'b0);
    send_sample(4700, 1'b0, 1'b0);
    send_sample(5300, 1'b0, 1'b0);
    send_sample(5301, 1'b0, 1'b0);
    send_sample(4699, 1'b0, 1'b0);
    send_sample(5000, 1'b0, 1'b0);
    send_sample(4980, 1'b0, 1'b0);
    drain();

    // Zero fall rate, zero trend and crossed thresholds.
    configure(0, 0, 6000, 4000);
    send_sample(5000, 1'b1, 1'b0);
    send_sample(5000, 1'b1, 1'b0);
    send_sample(4999, 1'b0, 1'b1);
    send_sample(MAX_MV, 1'b0, 1'b1);
    drain();

    // All-ones writes: largest fall rate and trend, widest window.
    configure(16383, 16383, 0, MAX_MV);
    send_sample(MAX_MV, 1'b0, 1'b0);
    send_sample(0, 1'b1, 1'b1);
    send_sample(MAX_MV, 1'b0, 1'b0);
    send_sample(1000, 1'b0, 1'b0);
    send_sample(0, 1'b1, 1'b1);
    drain();

    // Random phases under a range of settings.
    for (int p = 0; p < 6; p++) begin
      idle_on = ($urandom_range(0, 3) != 0);
      case (p)
        1: configure(1000, 1, 0, MAX_MV);
        2: configure(1, 15, MAX_MV, 0);
        3: configure($urandom_range(0, 16383), $urandom_range(0, 16383),
                     $urandom_range(0, 16383), $urandom_range(0, 16383));
        5: configure($urandom_range(0, 30), $urandom_range(0, 2),
                     $urandom_range(3000, 5000), $urandom_range(5000, 7000));
        default: configure($urandom_range(1, 200), $urandom_range(1, 6),
                           $urandom_range(2000, 6000), $urandom_range(6000, 9000));
      endcase
      random_phase(25, p == 0);
      drain();
    end

    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Watchdog.
  initial begin
    #400000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
